>>> hdl/ddo_pkg.sv
// Package for the differential drive odometry block: constants, arctangent table.
// No dependencies.
package ddo_pkg;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int POS_FRAC_DEF = 16;
	localparam int CORDIC_ITER_DEF = 16;
	localparam logic [15:0] MPS_RESET = 16'd8454;
	localparam logic [15:0] WB_RESET = 16'd13440;
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [19:0] GAIN_INV_Q20 = 20'd636751;
	localparam logic CFG_MPS = 1'b0;
	localparam logic CFG_WB = 1'b1;

	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'h20000000;
				5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B;
				5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43;
				5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E;
				5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53;
				5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA;
				5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30;
				5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C;
				5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3;
				5'd23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction
endpackage

>>> hdl/differential_drive_odometry.sv
// Differential drive odometry top level: sequencer, divider and CORDIC datapath.
// Depends on ddo_pkg.
//
// Dead-reckoning pose update. Each transfer on the input channel carries the
// current left and right encoder counts. The block takes the wrapped step
// differences and scales them by mm_per_step. It divides the wheel travel
// difference by wheel_base to get the heading change, using a restoring divider
// that makes one quotient bit a cycle. It then rotates the distance by the
// heading plus half the change, using a shared CORDIC stage that does one
// micro-rotation a cycle, and adds the result to the position. One shared
// multiplier (at most 34 x 31 bits at defaults) serves every product over
// successive states. One result transfer follows each input transfer.
// Most of an item's work lies in the division loop and the CORDIC loop. The
// block takes no new transfer until the current item has been committed and
// the sequencer is back in idle. in_stall is high while an item is in work.
// A finished pose waits in the output registers, so the next item can start.
// Its commit holds only while the previous pose has not been taken.
// Configuration writes must happen while idle.
module differential_drive_odometry #(
	parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF,
	parameter int POSITION_FRACTION_BITS = ddo_pkg::POS_FRAC_DEF,
	parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] left_count,
	input  logic [15:0] right_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic [15:0] pose_heading
);
	localparam int NW = 66;   // numerator magnitude: 17+16+30 bits, plus margin
	localparam int DW = 16 + 40 - ANGLE_BITS + 1;
	localparam int XW = POSITION_FRACTION_BITS + 18;   // CORDIC width
	localparam int MA = (XW > 33) ? XW : 33;           // multiplier operand a
	localparam int MP = MA + 31;                       // multiplier product
	localparam int ITW = $clog2(NW + 1);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_MUL1 = 8'b00000010,
		ST_MUL2 = 8'b00000100,
		ST_MUL3 = 8'b00001000,
		ST_DIV  = 8'b00010000,
		ST_PREP = 8'b00100000,
		ST_ROT  = 8'b01000000,
		ST_GAIN = 8'b10000000
	} state_t;

	state_t state_q;
	logic [15:0] mps_q, wb_q;
	logic [31:0] pos_x_q, pos_y_q;
	logic [ANGLE_BITS-1:0] head_q;
	logic [15:0] prev_l_q, prev_r_q;
	logic signed [17:0] sum_q, dif_q;
	logic signed [XW-1:0] dist_q;
	logic [NW-1:0] num_q, quo_q;
	logic [DW-1:0] rem_q;
	logic neg_q;
	logic [ITW-1:0] cnt_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic signed [ANGLE_BITS:0] delta_q;
	logic out_valid_q;
	logic gsel_q;
	logic [31:0] out_x_q, out_y_q;
	logic [15:0] out_h_q;

	// shared multiplier operands
	logic signed [MA-1:0] mul_a;
	logic signed [30:0] mul_b;
	logic signed [MP-1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic [DW-1:0] divisor;
	assign divisor = {1'b0, (wb_q == 16'd0) ? 16'd1 : wb_q, {(40 - ANGLE_BITS){1'b0}}};

	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};

	logic signed [ANGLE_BITS:0] quo_s;
	assign quo_s = neg_q ? -$signed(quo_q[ANGLE_BITS:0]) : $signed(quo_q[ANGLE_BITS:0]);

	logic [ANGLE_BITS-1:0] ang_sum;
	logic [31:0] ang32;
	assign ang_sum = head_q + quo_s[ANGLE_BITS:1];
	assign ang32 = {ang_sum, {(32 - ANGLE_BITS){1'b0}}};

	logic [4:0] it;
	logic signed [XW-1:0] xs, ys;
	assign it = cnt_q[4:0];
	assign xs = x_q >>> it;
	assign ys = y_q >>> it;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL1: begin
				mul_a = MA'(sum_q);
				mul_b = 31'({1'b0, mps_q});
			end
			ST_MUL2: begin
				mul_a = MA'(dif_q);
				mul_b = 31'({1'b0, mps_q});
			end
			ST_MUL3: begin
				mul_a = MA'({1'b0, num_q[31:0]});
				mul_b = 31'({1'b0, ddo_pkg::INV_TWO_PI_Q32});
			end
			ST_GAIN: begin
				mul_a = MA'(gsel_q ? y_q : x_q);
				mul_b = 31'({1'b0, ddo_pkg::GAIN_INV_Q20});
			end
			default: ;
		endcase
	end

	logic signed [MP-1:0] absn;
	assign absn = mul_p[MP-1] ? -mul_p : mul_p;
	logic [31:0] gshift;
	assign gshift = mul_p[51:20];

	logic [ANGLE_BITS-1:0] head_nx;
	assign head_nx = head_q + delta_q[ANGLE_BITS-1:0];

	// commit the pose once the previous one has been taken
	logic commit;
	assign commit = (state_q == ST_GAIN) && gsel_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mps_q <= ddo_pkg::MPS_RESET;
			wb_q <= ddo_pkg::WB_RESET;
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			out_valid_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_h_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ddo_pkg::CFG_MPS: mps_q <= cfg_data;
					ddo_pkg::CFG_WB: wb_q <= cfg_data;
				endcase
			end
			if (commit) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						// form signed wrapped step differences
						sum_q <= 18'($signed(16'(left_count - prev_l_q)))
							+ 18'($signed(16'(right_count - prev_r_q)));
						dif_q <= 18'($signed(16'(right_count - prev_r_q)))
							- 18'($signed(16'(left_count - prev_l_q)));
						prev_l_q <= left_count;
						prev_r_q <= right_count;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					// floor((dl+dr)*mps*2^P / 2^17)
					dist_q <= XW'((mul_p <<< POSITION_FRACTION_BITS) >>> 17);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					// keep sign and magnitude of (dr-dl)*mps
					neg_q <= mul_p[MP-1];
					num_q <= NW'(absn);
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					num_q <= NW'(mul_p);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// one quotient bit a cycle
					if (!rem_sub[DW]) begin
						rem_q <= rem_sub[DW-1:0];
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[DW-1:0];
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					num_q <= {num_q[NW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITW'(NW - 1)) state_q <= ST_PREP;
				end
				ST_PREP: begin
					// fold the angle into the right half plane
					delta_q <= quo_s;
					y_q <= '0;
					cnt_q <= '0;
					if ($signed(ang32) > 32'sh40000000) begin
						x_q <= -dist_q;
						z_q <= 34'($signed(ang32)) - 34'sh80000000;
					end else if ($signed(ang32) < -32'sh40000000) begin
						x_q <= -dist_q;
						z_q <= 34'($signed(ang32)) + 34'sh80000000;
					end else begin
						x_q <= dist_q;
						z_q <= 34'($signed(ang32));
					end
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 34'(ddo_pkg::atan_turns(it));
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 34'(ddo_pkg::atan_turns(it));
					end
					cnt_q <= cnt_q + 1'b1;
					gsel_q <= 1'b0;
					if (cnt_q == ITW'(CORDIC_ITERATIONS - 1)) state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					// apply gain to x, then y; hold until the output register is free
					if (!gsel_q) begin
						pos_x_q <= pos_x_q + gshift;
						gsel_q <= 1'b1;
					end else if (commit) begin
						pos_y_q <= pos_y_q + gshift;
						head_q <= head_nx;
						out_x_q <= pos_x_q;
						out_y_q <= pos_y_q + gshift;
						out_h_q <= 16'({head_nx, 16'h0} >> ANGLE_BITS);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign pose_x = $signed(out_x_q);
	assign pose_y = $signed(out_y_q);
	assign pose_heading = out_h_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_MUL1)
		else $error("accepted item did not start");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_GAIN)
		else $error("result without finished item");
endmodule
